// ===== hdl/ott_pkg.sv =====
// Shared types and codes for the obligation tracking table.
package ott_pkg;

   localparam int KEY_W   = 32;
   localparam int COUNT_W = 7;

   typedef enum logic [2:0] {
      OP_APPEND        = 3'd0,
      OP_TO_QUEUED     = 3'd1,
      OP_TO_PREPARED   = 3'd2,
      OP_TO_SUBMITTED  = 3'd3,
      OP_TO_JOINED     = 3'd4,
      OP_LOSE_LIVE     = 3'd5,
      OP_LOSE_UNSUB    = 3'd6,
      OP_CLEAR         = 3'd7
   } opcode_type;

   // Phase codes; 6 and 7 never appear in a used entry.
   typedef enum logic [2:0] {
      PH_ACCEPTED  = 3'd0,
      PH_QUEUED    = 3'd1,
      PH_PREPARED  = 3'd2,
      PH_SUBMITTED = 3'd3,
      PH_JOINED    = 3'd4,
      PH_LOST      = 3'd5
   } phase_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [KEY_W-1:0]   gesture_key;
      logic [KEY_W-1:0]   sequence_key;
      logic [KEY_W-1:0]   work_id;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] marked_lost;
      logic               any_live;
      logic               any_runnable;
      logic               balance_exact;
      logic               clean_balance;
      logic [KEY_W-1:0]   accepted_total;
      logic [KEY_W-1:0]   joined_total;
      logic [KEY_W-1:0]   lost_total;
   } rsp_type;

   // One table entry as held in memory.
   typedef struct packed {
      logic [KEY_W-1:0] gesture;
      logic [KEY_W-1:0] seq_key;
      logic [KEY_W-1:0] work;
      phase_type        phase;
   } entry_type;

endpackage

// ===== hdl/ott_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ott_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/obligation_tracking_table_top.sv =====
// Obligation tracking table: top level with scan sequencer and counters.
//
// Usage:
//   req_* carries one request (opcode, gesture/sequence key, work id) with
//   valid/ready; rsp_* returns exactly one result per request with
//   valid/ready. There is no configuration port.
//   Entry keys, work ids and phases live in one RAM of TABLE_DEPTH words;
//   a per-entry used bit sits in flip-flops. Each request (other than
//   clear) walks the RAM once, one read per cycle, checking keys, finding
//   the first matching entry and marking entries lost for the bulk ops,
//   then commits at most one write-back and updates the counters.
// Sequence:
//   accept, scan (one RAM read per entry, each entry evaluated once its
//   registered read data returns), commit and result forming; clear skips
//   the scan. A new request is taken only after the result is formed.
// Reset:
//   synchronous, active high; clears used bits, write pointer and running
//   totals. The RAM contents are not cleared; the used bits gate them.
// Stall:
//   the result sits in an output register; the next request may be taken
//   and scanned while it waits, and the block holds in its last state
//   until the register is free.
module obligation_tracking_table_top
   import ott_pkg::*;
#(
   parameter int TABLE_DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_FORM
   } state_type;

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [TABLE_DEPTH-1:0]  used_ff, used_in;
   logic [IDX_W-1:0]        wp_ff, wp_in;
   logic [KEY_W-1:0]        accepted_ff, accepted_in;
   logic [KEY_W-1:0]        submitted_ff, submitted_in;
   logic [KEY_W-1:0]        joined_ff, joined_in;
   logic [KEY_W-1:0]        lost_ff, lost_in;

   // scan pipeline
   logic [CNT_W-1:0]        issue_cnt_ff, issue_cnt_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;

   // scan results
   logic                    dup_ff, dup_in;
   logic                    wp_live_ff, wp_live_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        match_idx_ff, match_idx_in;
   logic [KEY_W-1:0]        match_work_ff, match_work_in;
   logic [COUNT_W-1:0]      marked_ff, marked_in;
   logic [COUNT_W-1:0]      live_cnt_ff, live_cnt_in;
   logic [COUNT_W-1:0]      run_cnt_ff, run_cnt_in;
   logic                    ok_ff, ok_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // RAM port
   logic                    ram_we, ram_re;
   logic [IDX_W-1:0]        ram_wa, ram_ra;
   entry_type               ram_wd;
   logic [$bits(entry_type)-1:0] ram_rd_data;

   ott_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      entry_type  ent;
      logic       ent_used;
      logic       ent_live;
      logic       ent_lose;
      logic       key_hit;
      phase_type  expected;
      phase_type  advanced;
      logic       is_lose_op;

      ent        = entry_type'(ram_rd_data);
      ent_used   = used_ff[rd_idx_ff];
      ent_live   = ent_used && (ent.phase != PH_JOINED) && (ent.phase != PH_LOST);
      key_hit    = ent_used && (ent.gesture == req_ff.gesture_key) &&
                   (ent.seq_key == req_ff.sequence_key);
      expected   = phase_type'(3'(req_ff.opcode) - 3'd1);
      advanced   = phase_type'(3'(expected) + 3'd1);
      is_lose_op = (req_ff.opcode == OP_LOSE_LIVE) || (req_ff.opcode == OP_LOSE_UNSUB);
      ent_lose   = ent_live && ((req_ff.opcode == OP_LOSE_LIVE) ||
                   ((req_ff.opcode == OP_LOSE_UNSUB) && (ent.phase != PH_SUBMITTED)));

      state_in      = state_ff;
      req_in        = req_ff;
      used_in       = used_ff;
      wp_in         = wp_ff;
      accepted_in   = accepted_ff;
      submitted_in  = submitted_ff;
      joined_in     = joined_ff;
      lost_in       = lost_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      dup_in        = dup_ff;
      wp_live_in    = wp_live_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_work_in = match_work_ff;
      marked_in     = marked_ff;
      live_cnt_in   = live_cnt_ff;
      run_cnt_in    = run_cnt_ff;
      ok_in         = ok_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      ram_we = 1'b0;
      ram_wa = rd_idx_ff;
      ram_wd = '{gesture: ent.gesture, seq_key: ent.seq_key, work: ent.work,
                 phase: PH_LOST};
      ram_re = 1'b0;
      ram_ra = issue_cnt_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               issue_cnt_in = '0;
               dup_in       = 1'b0;
               wp_live_in   = 1'b0;
               found_in     = 1'b0;
               marked_in    = '0;
               live_cnt_in  = '0;
               run_cnt_in   = '0;
               state_in     = (req_data.opcode == OP_CLEAR) ? ST_COMMIT : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read per cycle
            if (issue_cnt_ff < DEPTH_CNT) begin
               ram_re       = 1'b1;
               rd_vld_in    = 1'b1;
               rd_idx_in    = issue_cnt_ff[IDX_W-1:0];
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
            // evaluate the entry read last cycle
            if (rd_vld_ff) begin
               if (key_hit) begin
                  dup_in = 1'b1;
               end
               if (rd_idx_ff == wp_ff) begin
                  wp_live_in = ent_live;
               end
               if (key_hit && (ent.phase == expected) && !found_ff) begin
                  found_in      = 1'b1;
                  match_idx_in  = rd_idx_ff;
                  match_work_in = ent.work;
               end
               if (is_lose_op && ent_lose) begin
                  ram_we    = 1'b1;
                  marked_in = marked_ff + COUNT_W'(1);
               end
               if (ent_live && !ent_lose) begin
                  live_cnt_in = live_cnt_ff + COUNT_W'(1);
                  if (ent.phase != PH_SUBMITTED) begin
                     run_cnt_in = run_cnt_ff + COUNT_W'(1);
                  end
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_COMMIT;
               end
            end
         end

         ST_COMMIT: begin
            ok_in    = 1'b1;
            state_in = ST_FORM;
            case (req_ff.opcode) inside
               OP_APPEND: begin
                  ok_in = (req_ff.gesture_key != '0) && (req_ff.sequence_key != '0) &&
                          !dup_ff && !wp_live_ff;
                  ram_wa = wp_ff;
                  ram_wd = '{gesture: req_ff.gesture_key, seq_key: req_ff.sequence_key,
                             work: '0, phase: PH_ACCEPTED};
                  if (ok_in) begin
                     ram_we          = 1'b1;
                     used_in[wp_ff]  = 1'b1;
                     wp_in           = (wp_ff == LAST_IDX) ? '0 : wp_ff + IDX_W'(1);
                     accepted_in     = accepted_ff + 32'd1;
                     live_cnt_in     = live_cnt_ff + COUNT_W'(1);
                     run_cnt_in      = run_cnt_ff + COUNT_W'(1);
                  end
               end
               OP_TO_QUEUED, OP_TO_PREPARED, OP_TO_SUBMITTED, OP_TO_JOINED: begin
                  ok_in = found_ff && ((expected == PH_ACCEPTED) ?
                          (req_ff.work_id != '0) : (match_work_ff == req_ff.work_id));
                  ram_wa = match_idx_ff;
                  // the bound work id equals the request's in both cases
                  ram_wd = '{gesture: req_ff.gesture_key, seq_key: req_ff.sequence_key,
                             work: req_ff.work_id, phase: advanced};
                  if (ok_in) begin
                     ram_we = 1'b1;
                     if (advanced == PH_SUBMITTED) begin
                        submitted_in = submitted_ff + 32'd1;
                        run_cnt_in   = run_cnt_ff - COUNT_W'(1);
                     end else if (advanced == PH_JOINED) begin
                        joined_in   = joined_ff + 32'd1;
                        live_cnt_in = live_cnt_ff - COUNT_W'(1);
                     end
                  end
               end
               OP_LOSE_LIVE, OP_LOSE_UNSUB: begin
                  lost_in = lost_ff + 32'(marked_ff);
               end
               default: begin
                  // clear
                  used_in      = '0;
                  wp_in        = '0;
                  accepted_in  = '0;
                  submitted_in = '0;
                  joined_in    = '0;
                  lost_in      = '0;
                  live_cnt_in  = '0;
                  run_cnt_in   = '0;
               end
            endcase
         end

         ST_FORM: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.ok             = ok_ff;
               rsp_in.marked_lost    = marked_ff;
               rsp_in.any_live       = (live_cnt_ff != '0);
               rsp_in.any_runnable   = (run_cnt_ff != '0);
               rsp_in.balance_exact  = (accepted_ff ==
                                        (joined_ff + lost_ff + 32'(live_cnt_ff)));
               rsp_in.clean_balance  = (lost_ff == '0) && (accepted_ff == submitted_ff) &&
                                       (submitted_ff == joined_ff);
               rsp_in.accepted_total = accepted_ff;
               rsp_in.joined_total   = joined_ff;
               rsp_in.lost_total     = lost_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         wp_ff        <= '0;
         accepted_ff  <= '0;
         submitted_ff <= '0;
         joined_ff    <= '0;
         lost_ff      <= '0;
         issue_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         wp_ff        <= wp_in;
         accepted_ff  <= accepted_in;
         submitted_ff <= submitted_in;
         joined_ff    <= joined_in;
         lost_ff      <= lost_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      rd_idx_ff     <= rd_idx_in;
      dup_ff        <= dup_in;
      wp_live_ff    <= wp_live_in;
      found_ff      <= found_in;
      match_idx_ff  <= match_idx_in;
      match_work_ff <= match_work_in;
      marked_ff     <= marked_in;
      live_cnt_ff   <= live_cnt_in;
      run_cnt_ff    <= run_cnt_in;
      ok_ff         <= ok_in;
      rsp_ff        <= rsp_in;
   end

   // A result is only loaded from the result-forming state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FORM))
      else $error("result raised outside result-forming state");

   // A successful append marks its slot used and bumps the accepted count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && req_ff.opcode == OP_APPEND && ok_in) |=>
      (used_ff[$past(wp_ff)] && (accepted_ff == $past(accepted_ff) + 32'd1)))
      else $error("append commit lost its slot or count");

   // Live entries never outnumber used slots; runnable ones are live.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FORM) |->
      ((live_cnt_ff <= $countones(used_ff)) && (run_cnt_ff <= live_cnt_ff)))
      else $error("live or runnable count out of range");

   // A bulk operation never marks more entries than the table holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.marked_lost <= COUNT_W'(TABLE_DEPTH)))
      else $error("marked count exceeds table depth");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the obligation tracking table.
`timescale 1ns / 100ps

module tb_top;
   import ott_pkg::*;

   localparam int DEPTH        = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 175;
   localparam int MAX_REPORTS  = 10;
   localparam logic [KEY_W-1:0] KEY_MAX = '1;

   // Directed row: the request plus, where it is obvious, the typed-in status.
   typedef struct {
      req_type req;
      bit      pinned;
      rsp_type status;
   } probe_row_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Predictor copy of the table.
   bit               tbl_used     [DEPTH];
   logic [KEY_W-1:0] tbl_gesture  [DEPTH];
   logic [KEY_W-1:0] tbl_sequence [DEPTH];
   logic [KEY_W-1:0] tbl_work     [DEPTH];
   phase_type        tbl_phase    [DEPTH];
   int unsigned      ring_ptr;
   logic [KEY_W-1:0] n_accepted;
   logic [KEY_W-1:0] n_submitted;
   logic [KEY_W-1:0] n_joined;
   logic [KEY_W-1:0] n_lost;

   rsp_type       status_due [$];
   probe_row_type directed_plan [$];
   rsp_type       status_want;

   int unsigned idle_plan  [4] = '{0, 59, 0, 28};
   int unsigned stall_plan [4] = '{0, 0, 59, 28};
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int          hold_asked = 0;
   int          hold_seen  = 0;
   int          hold_left  = 0;
   int          fail_count = 0;
   int          results_seen = 0;
   int          cycle_count;

   obligation_tracking_table_top #(
      .TABLE_DEPTH (DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit entry_live(int i);
      return tbl_used[i] && tbl_phase[i] != PH_JOINED && tbl_phase[i] != PH_LOST;
   endfunction

   function automatic void table_wipe();
      for (int i = 0; i < DEPTH; i++) begin
         tbl_used[i]     = 1'b0;
         tbl_gesture[i]  = '0;
         tbl_sequence[i] = '0;
         tbl_work[i]     = '0;
         tbl_phase[i]    = PH_ACCEPTED;
      end
      ring_ptr    = 0;
      n_accepted  = '0;
      n_submitted = '0;
      n_joined    = '0;
      n_lost      = '0;
   endfunction

   // Marks live entries lost; the unsubmitted sweep spares submitted ones.
   function automatic logic [COUNT_W-1:0] table_lose(bit spare_submitted);
      logic [COUNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (entry_live(i) && !(spare_submitted && tbl_phase[i] == PH_SUBMITTED)) begin
            tbl_phase[i] = PH_LOST;
            n++;
         end
      end
      n_lost += KEY_W'(n);
      return n;
   endfunction

   function automatic rsp_type table_step(req_type r);
      rsp_type     s;
      phase_type   want;
      phase_type   goal;
      bit          found;
      int unsigned live;
      s    = '0;
      s.ok = 1'b1;
      case (r.opcode)
         OP_APPEND: begin
            s.ok = (r.gesture_key != '0) && (r.sequence_key != '0);
            for (int i = 0; i < DEPTH; i++)
               if (tbl_used[i] && tbl_gesture[i] == r.gesture_key &&
                   tbl_sequence[i] == r.sequence_key)
                  s.ok = 1'b0;
            if (entry_live(ring_ptr))
               s.ok = 1'b0;
            if (s.ok) begin
               tbl_used[ring_ptr]     = 1'b1;
               tbl_gesture[ring_ptr]  = r.gesture_key;
               tbl_sequence[ring_ptr] = r.sequence_key;
               tbl_work[ring_ptr]     = '0;
               tbl_phase[ring_ptr]    = PH_ACCEPTED;
               ring_ptr               = (ring_ptr + 1) % DEPTH;
               n_accepted++;
            end
         end
         OP_TO_QUEUED, OP_TO_PREPARED, OP_TO_SUBMITTED, OP_TO_JOINED: begin
            case (r.opcode)
               OP_TO_QUEUED:    begin want = PH_ACCEPTED;  goal = PH_QUEUED;    end
               OP_TO_PREPARED:  begin want = PH_QUEUED;    goal = PH_PREPARED;  end
               OP_TO_SUBMITTED: begin want = PH_PREPARED;  goal = PH_SUBMITTED; end
               default:         begin want = PH_SUBMITTED; goal = PH_JOINED;    end
            endcase
            s.ok  = 1'b0;
            found = 1'b0;
            // first entry in slot order with key and phase decides
            for (int i = 0; i < DEPTH; i++) begin
               if (!found && tbl_used[i] && tbl_gesture[i] == r.gesture_key &&
                   tbl_sequence[i] == r.sequence_key && tbl_phase[i] == want) begin
                  found = 1'b1;
                  if (want == PH_ACCEPTED ? r.work_id != '0 : tbl_work[i] == r.work_id) begin
                     if (want == PH_ACCEPTED)
                        tbl_work[i] = r.work_id;
                     tbl_phase[i] = goal;
                     if (goal == PH_SUBMITTED)
                        n_submitted++;
                     else if (goal == PH_JOINED)
                        n_joined++;
                     s.ok = 1'b1;
                  end
               end
            end
         end
         OP_LOSE_LIVE:  s.marked_lost = table_lose(1'b0);
         OP_LOSE_UNSUB: s.marked_lost = table_lose(1'b1);
         default:       table_wipe();
      endcase

      live = 0;
      for (int i = 0; i < DEPTH; i++) begin
         if (entry_live(i)) begin
            live++;
            if (tbl_phase[i] != PH_SUBMITTED)
               s.any_runnable = 1'b1;
         end
      end
      s.any_live       = (live != 0);
      s.balance_exact  = (n_accepted == n_joined + n_lost + KEY_W'(live));
      s.clean_balance  = (n_lost == '0) && (n_accepted == n_submitted) &&
                         (n_submitted == n_joined);
      s.accepted_total = n_accepted;
      s.joined_total   = n_joined;
      s.lost_total     = n_lost;
      return s;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic rsp_type outcome(bit ok, bit live, bit run, bit bal, bit clean,
                                       logic [KEY_W-1:0] acc, logic [KEY_W-1:0] joins,
                                       logic [KEY_W-1:0] lost_n);
      rsp_type s;
      s                = '0;
      s.ok             = ok;
      s.any_live       = live;
      s.any_runnable   = run;
      s.balance_exact  = bal;
      s.clean_balance  = clean;
      s.accepted_total = acc;
      s.joined_total   = joins;
      s.lost_total     = lost_n;
      return s;
   endfunction

   function automatic void add_row(opcode_type op, logic [KEY_W-1:0] g,
                                   logic [KEY_W-1:0] sq, logic [KEY_W-1:0] w,
                                   bit pinned, rsp_type st);
      probe_row_type row;
      row.req.opcode       = op;
      row.req.gesture_key  = g;
      row.req.sequence_key = sq;
      row.req.work_id      = w;
      row.pinned           = pinned;
      row.status           = st;
      directed_plan.push_back(row);
   endfunction

   // Mostly well-formed lifecycles drawn from the current table, plus noise.
   function automatic req_type pick_request();
      req_type     r;
      int unsigned roll;
      int          k;
      roll           = $urandom_range(99);
      k              = $urandom_range(DEPTH - 1);
      r.opcode       = OP_APPEND;
      // small key space makes duplicates common
      r.gesture_key  = $urandom_range(1) ? $urandom_range(1, 6) : $urandom;
      r.sequence_key = $urandom_range(1) ? $urandom_range(1, 6) : $urandom;
      r.work_id      = $urandom_range(1) ? $urandom_range(1, 3) : $urandom;
      if (roll < 30 || (roll < 85 && !tbl_used[k])) begin
         if ($urandom_range(19) == 0)
            r.gesture_key = '0;
         else if ($urandom_range(19) == 0)
            r.sequence_key = '0;
      end else if (roll < 80) begin
         r.gesture_key  = tbl_gesture[k];
         r.sequence_key = tbl_sequence[k];
         case (tbl_phase[k])
            PH_ACCEPTED:  r.opcode = OP_TO_QUEUED;   // binds the fresh work id
            PH_QUEUED:    begin r.opcode = OP_TO_PREPARED;  r.work_id = tbl_work[k]; end
            PH_PREPARED:  begin r.opcode = OP_TO_SUBMITTED; r.work_id = tbl_work[k]; end
            PH_SUBMITTED: begin r.opcode = OP_TO_JOINED;    r.work_id = tbl_work[k]; end
            default:      r.opcode = opcode_type'($urandom_range(OP_TO_QUEUED, OP_TO_JOINED));
         endcase
         // broken moves: stale work id or skipped phase
         if ($urandom_range(9) == 0)
            r.work_id = r.work_id ^ (32'd1 << $urandom_range(KEY_W - 1));
         if ($urandom_range(9) == 0)
            r.opcode = opcode_type'($urandom_range(OP_TO_QUEUED, OP_TO_JOINED));
      end else if (roll < 85) begin
         r.gesture_key  = tbl_gesture[k];
         r.sequence_key = tbl_sequence[k];
      end else if (roll < 88) begin
         r.opcode = OP_LOSE_UNSUB;
      end else if (roll < 90) begin
         r.opcode = OP_LOSE_LIVE;
      end else if (roll < 91) begin
         r.opcode = OP_CLEAR;
      end else begin
         r.opcode = opcode_type'($urandom_range(OP_CLEAR));
      end
      return r;
   endfunction

   // Offer one request, wait for the handshake, then log what it should return.
   task automatic issue(input req_type r, input bit pinned, input rsp_type pinned_status);
      rsp_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predicted = table_step(r);
      status_due.push_back(pinned ? pinned_status : predicted);
   endtask

   initial begin
      table_wipe();

      // after reset, zero keys, max key lifecycle, work checks, ring wrap, busy slot, bulk losses, clear
      add_row(OP_LOSE_LIVE,    '0,      '0,      '0,      1, outcome(1,0,0,1,1, 0,0,0));
      add_row(OP_APPEND,       '0,      32'd5,   '0,      1, outcome(0,0,0,1,1, 0,0,0));
      add_row(OP_APPEND,       32'd5,   '0,      '0,      1, outcome(0,0,0,1,1, 0,0,0));
      add_row(OP_APPEND,       KEY_MAX, KEY_MAX, '0,      0, '0);
      add_row(OP_APPEND,       KEY_MAX, KEY_MAX, '0,      1, outcome(0,1,1,1,0, 1,0,0));
      add_row(OP_TO_QUEUED,    KEY_MAX, KEY_MAX, '0,      1, outcome(0,1,1,1,0, 1,0,0));
      add_row(OP_TO_QUEUED,    KEY_MAX, KEY_MAX, KEY_MAX, 0, '0);
      add_row(OP_TO_PREPARED,  KEY_MAX, KEY_MAX, 32'd1,   0, '0);
      add_row(OP_TO_PREPARED,  KEY_MAX, KEY_MAX, KEY_MAX, 0, '0);
      add_row(OP_TO_SUBMITTED, KEY_MAX, KEY_MAX, KEY_MAX, 0, '0);
      add_row(OP_TO_JOINED,    KEY_MAX, KEY_MAX, KEY_MAX, 0, '0);
      add_row(OP_TO_JOINED,    KEY_MAX, KEY_MAX, KEY_MAX, 1, outcome(0,0,0,1,1, 1,1,0));
      add_row(OP_APPEND,       32'd1,   32'd1,   '0,      0, '0);
      add_row(OP_TO_SUBMITTED, 32'd1,   32'd1,   '0,      0, '0);
      for (int g = 2; g <= 7; g++)
         add_row(OP_APPEND, KEY_W'(g), 32'd1, '0, 0, '0);
      add_row(OP_APPEND,       32'd9,   32'd1,   '0,      0, '0);
      add_row(OP_APPEND,       32'd10,  32'd1,   '0,      1, outcome(0,1,1,1,0, 9,1,0));
      add_row(OP_TO_QUEUED,    32'd2,   32'd1,   32'h8000_0000, 0, '0);
      add_row(OP_LOSE_UNSUB,   '0,      '0,      '0,      0, '0);
      add_row(OP_LOSE_LIVE,    '0,      '0,      '0,      0, '0);
      add_row(OP_CLEAR,        KEY_MAX, KEY_MAX, KEY_MAX, 1, outcome(1,0,0,1,1, 0,0,0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         issue(directed_plan[i].req, directed_plan[i].pinned, directed_plan[i].status);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct   = idle_plan[ph];
         recv_stall_pct <= stall_plan[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while requests keep coming
            if (n == 40)
               hold_asked <= hold_asked + 1;
            // sender pauses until every result is back
            if (n == 100) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (status_due.size() != 0);
            end
            issue(pick_request(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
      repeat (2 * DEPTH + 8) @(posedge clock);

      fail_count += status_due.size();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic log_failure(input string what, input rsp_type want, input rsp_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%s at result %0d", what, results_seen);
         $display("  exp ok=%0d mk=%0d lv=%0d rn=%0d bal=%0d cln=%0d acc=%0d jn=%0d lost=%0d",
                  want.ok, want.marked_lost, want.any_live, want.any_runnable,
                  want.balance_exact, want.clean_balance, want.accepted_total,
                  want.joined_total, want.lost_total);
         $display("  got ok=%0d mk=%0d lv=%0d rn=%0d bal=%0d cln=%0d acc=%0d jn=%0d lost=%0d",
                  got.ok, got.marked_lost, got.any_live, got.any_runnable,
                  got.balance_exact, got.clean_balance, got.accepted_total,
                  got.joined_total, got.lost_total);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_due.size() == 0) begin
            log_failure("unexpected result", '0, rsp_data);
         end else begin
            status_want = status_due.pop_front();
            if (rsp_data.ok             !== status_want.ok             ||
                rsp_data.marked_lost    !== status_want.marked_lost    ||
                rsp_data.any_live       !== status_want.any_live       ||
                rsp_data.any_runnable   !== status_want.any_runnable   ||
                rsp_data.balance_exact  !== status_want.balance_exact  ||
                rsp_data.clean_balance  !== status_want.clean_balance  ||
                rsp_data.accepted_total !== status_want.accepted_total ||
                rsp_data.joined_total   !== status_want.joined_total   ||
                rsp_data.lost_total     !== status_want.lost_total)
               log_failure("status mismatch", status_want, rsp_data);
         end
         results_seen++;
      end
   end

   // Watchdog.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== obligation_tracking_table_top.f =====
hdl/ott_pkg.sv
hdl/ott_ram.sv
hdl/obligation_tracking_table_top.sv
dv/tb_top.sv
